// File: design/rtsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the refcounted tile slot allocator.
// No dependencies; used by the top level and its checker.
package rtsa_pkg;

    // Default geometry
    localparam int SLOTS_DEF = 512;
    localparam int TILES_DEF = 1024;

    // Item field widths
    localparam int TILE_ID_W = 10;
    localparam int SLOT_ID_W = 9;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 24;   // tile_id + slot_id = 19 bits, padded to bytes
    localparam int M_TDATA_W = 16;   // slot + status = 12 bits, padded to bytes

    // Reference count / free link storage
    localparam int               COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request kinds
    localparam logic ACT_ACQUIRE = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NEW      = 3'd0,
        ST_HIT      = 3'd1,
        ST_FULL     = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_RELEASED = 3'd4
    } status_t;

endpackage

// File: design/refcounted_tile_slot_allocator.sv
`timescale 1ns / 1ps
// Acquire passes S_IDLE, S_LOOK and S_ACQ, release S_IDLE and S_REL; one item in flight,
// so a new request is taken only once the previous one has formed its result, set by the
// read-then-write sequence on the slot memory (one synchronous read per step).
// Result sits in an output register; a new item is taken while it waits.
// Reset: after rst_n rises a clearing pass unmaps every entry and rebuilds the free list;
// no item is accepted during it.
module refcounted_tile_slot_allocator
    import rtsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int TILES = TILES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] tile_id, [18:10] slot_id, rest zero
    input  logic                 s_tuser,   // [0] action
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [8:0] slot, [11:9] status, rest zero
);

    localparam int SW    = $clog2(SLOTS);
    localparam int TW    = $clog2(TILES);
    localparam int SE_W  = 1 + TW + COUNT_W;
    localparam int CLR_N = (TILES > SLOTS) ? TILES : SLOTS;
    localparam int CLR_W = $clog2(CLR_N);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_ACQ   = 5'b01000,
        S_REL   = 5'b10000
    } fsm_t;

    // Memories: tile map {valid, slot}, slot entry {valid, tile, count or free link}
    logic [SW:0]        tmap_mem [TILES];
    logic [SE_W-1:0]    slot_mem [SLOTS];

    logic [SW:0]        tmap_rd_reg;
    logic [SE_W-1:0]    smem_rd_reg;

    logic               tmap_we, tmap_re;
    logic [TW-1:0]      tmap_waddr, tmap_raddr;
    logic [SW:0]        tmap_wdata;
    logic               smem_we, smem_re;
    logic [SW-1:0]      smem_waddr, smem_raddr;
    logic [SE_W-1:0]    smem_wdata;

    // Slot entry read fields
    logic               smem_rd_valid;
    logic [TW-1:0]      smem_rd_tile;
    logic [COUNT_W-1:0] smem_rd_cnt;

    // Control and item registers
    fsm_t               state_reg, state_next;
    logic [CLR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [SW-1:0]      free_head_reg, free_head_next;
    logic [TW-1:0]      tile_reg, tile_next;
    logic [SW-1:0]      slot_reg, slot_next;
    logic               ign_reg, ign_next;
    logic               hit_reg, hit_next;
    logic               full_reg, full_next;
    logic               out_valid_reg, out_valid_next;
    logic [SLOT_ID_W-1:0] out_slot_reg, out_slot_next;
    status_t            out_status_reg, out_status_next;

    // Input decode
    logic [TILE_ID_W-1:0] in_tile;
    logic [SLOT_ID_W-1:0] in_slot;
    logic                 in_act;
    logic                 accept;
    logic                 out_free;
    logic                 tile_bad, slot_bad;
    logic                 look_hit;
    logic [SW-1:0]        look_slot;

    assign in_tile  = s_tdata[TILE_ID_W-1:0];
    assign in_slot  = s_tdata[TILE_ID_W+SLOT_ID_W-1:TILE_ID_W];
    assign in_act   = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign tile_bad = (in_tile == '0) || (32'(in_tile) >= TILES);
    assign slot_bad = (in_slot == '0) || (32'(in_slot) >= SLOTS);

    assign smem_rd_valid = smem_rd_reg[SE_W-1];
    assign smem_rd_tile  = smem_rd_reg[COUNT_W+TW-1:COUNT_W];
    assign smem_rd_cnt   = smem_rd_reg[COUNT_W-1:0];

    // Mapped tile hits its slot, otherwise take the free-list head
    assign look_hit  = tmap_rd_reg[SW];
    assign look_slot = look_hit ? tmap_rd_reg[SW-1:0] : free_head_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-SLOT_ID_W-STATUS_W){1'b0}}, out_status_reg, out_slot_reg};

    // Sequencer, memory port control and result formation
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_head_next  = free_head_reg;
        tile_next       = tile_reg;
        slot_next       = slot_reg;
        ign_next        = ign_reg;
        hit_next        = hit_reg;
        full_next       = full_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;

        tmap_we    = 1'b0;
        tmap_waddr = '0;
        tmap_wdata = '0;
        tmap_re    = 1'b0;
        tmap_raddr = TW'(in_tile);
        smem_we    = 1'b0;
        smem_waddr = '0;
        smem_wdata = '0;
        smem_re    = 1'b0;
        smem_raddr = SW'(in_slot);

        case (state_reg)
            S_CLEAR:
            begin
                // Unmap everything, chain slot i to i+1, last slot ends the list
                tmap_we    = (32'(clr_cnt_reg) < TILES);
                tmap_waddr = TW'(clr_cnt_reg);
                smem_we    = (32'(clr_cnt_reg) < SLOTS);
                smem_waddr = SW'(clr_cnt_reg);
                smem_wdata = {1'b0, {TW{1'b0}},
                              (32'(clr_cnt_reg) == SLOTS - 1) ? {COUNT_W{1'b0}}
                                                              : COUNT_W'(32'(clr_cnt_reg) + 1)};
                if (32'(clr_cnt_reg) == CLR_N - 1)
                    state_next = S_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    tmap_re   = 1'b1;
                    smem_re   = 1'b1;
                    tile_next = TW'(in_tile);
                    slot_next = SW'(in_slot);
                    if (in_act == ACT_RELEASE)
                    begin
                        ign_next   = slot_bad;
                        state_next = S_REL;
                    end
                    else
                    begin
                        ign_next   = tile_bad;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                // Fetch the slot entry: count (hit) or next free link (new)
                smem_re    = 1'b1;
                smem_raddr = look_slot;
                slot_next  = look_slot;
                hit_next   = look_hit;
                full_next  = !look_hit && (free_head_reg == '0);
                state_next = S_ACQ;
            end
            S_ACQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (ign_reg)
                    begin
                        out_slot_next   = '0;
                        out_status_next = ST_IGNORED;
                    end
                    else if (hit_reg)
                    begin
                        // saturating reference count
                        smem_we    = 1'b1;
                        smem_waddr = slot_reg;
                        smem_wdata = {smem_rd_valid, smem_rd_tile,
                                      (smem_rd_cnt == COUNT_MAX) ? smem_rd_cnt
                                                                 : smem_rd_cnt + COUNT_W'(1)};
                        out_slot_next   = SLOT_ID_W'(slot_reg);
                        out_status_next = ST_HIT;
                    end
                    else if (full_reg)
                    begin
                        out_slot_next   = '0;
                        out_status_next = ST_FULL;
                    end
                    else
                    begin
                        // pop the free list and map both directions
                        free_head_next  = SW'(smem_rd_cnt);
                        tmap_we         = 1'b1;
                        tmap_waddr      = tile_reg;
                        tmap_wdata      = {1'b1, slot_reg};
                        smem_we         = 1'b1;
                        smem_waddr      = slot_reg;
                        smem_wdata      = {1'b1, tile_reg, COUNT_W'(1)};
                        out_slot_next   = SLOT_ID_W'(slot_reg);
                        out_status_next = ST_NEW;
                    end
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (ign_reg || !smem_rd_valid)
                    begin
                        out_slot_next   = '0;
                        out_status_next = ST_IGNORED;
                    end
                    else
                    begin
                        out_slot_next   = SLOT_ID_W'(slot_reg);
                        out_status_next = ST_RELEASED;
                        smem_we         = 1'b1;
                        smem_waddr      = slot_reg;
                        if (smem_rd_cnt <= COUNT_W'(1))
                        begin
                            // last reference: unmap and push onto the free list
                            tmap_we        = 1'b1;
                            tmap_waddr     = smem_rd_tile;
                            tmap_wdata     = '0;
                            smem_wdata     = {1'b0, {TW{1'b0}}, COUNT_W'(free_head_reg)};
                            free_head_next = slot_reg;
                        end
                        else
                        begin
                            smem_wdata = {smem_rd_valid, smem_rd_tile,
                                          smem_rd_cnt - COUNT_W'(1)};
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            free_head_reg <= SW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        tile_reg       <= tile_next;
        slot_reg       <= slot_next;
        ign_reg        <= ign_next;
        hit_reg        <= hit_next;
        full_reg       <= full_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    // Tile map memory
    always_ff @(posedge clk)
    begin
        if (tmap_we)
            tmap_mem[tmap_waddr] <= tmap_wdata;
        if (tmap_re)
            tmap_rd_reg <= tmap_mem[tmap_raddr];
    end

    // Slot memory: owning tile and count / free link
    always_ff @(posedge clk)
    begin
        if (smem_we)
            slot_mem[smem_waddr] <= smem_wdata;
        if (smem_re)
            smem_rd_reg <= slot_mem[smem_raddr];
    end

endmodule

// File: design/rtsa_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the refcounted tile slot allocator, bound to the top level.
// Depends on rtsa_pkg for field widths and status codes.
module rtsa_checker
    import rtsa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [SLOT_ID_W-1:0] res_slot;
    logic [STATUS_W-1:0]  res_status;

    assign res_slot   = m_tdata[SLOT_ID_W-1:0];
    assign res_status = m_tdata[SLOT_ID_W+STATUS_W-1:SLOT_ID_W];

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in work");

    // Status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_status == ST_NEW || res_status == ST_HIT ||
                      res_status == ST_FULL || res_status == ST_IGNORED ||
                      res_status == ST_RELEASED))
        else $error("undefined status code");

    // Failed or ignored requests answer slot 0
    a_fail_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == ST_FULL || res_status == ST_IGNORED)) |-> (res_slot == '0))
        else $error("failed request carries a nonzero slot");

    // Reserved slot is never handed out or released
    a_slot_zero_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res_status == ST_NEW || res_status == ST_RELEASED)) |-> (res_slot != '0))
        else $error("reserved slot used");

    // Stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind refcounted_tile_slot_allocator rtsa_checker u_rtsa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/sv/slot_map_checker.sv
`timescale 1ns / 1ps
// Checker for the refcounted tile slot allocator: predicts each result from the
// accepted request items and compares it with the result stream. Uses rtsa_pkg.
module slot_map_checker
    import rtsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] tile_id, [18:10] slot_id, rest zero
    input  logic                 s_tuser,   // [0] action
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // [8:0] slot, [11:9] status, rest zero
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic [SLOT_ID_W-1:0] slot;
        status_t              status;
    } alloc_result_t;

    // Shadow copy of the allocator state
    logic [SLOT_ID_W-1:0] slot_of_tile   [TILES_DEF];
    logic                 tile_mapped    [TILES_DEF];
    logic [TILE_ID_W-1:0] tile_of_slot   [SLOTS_DEF];
    logic                 slot_mapped    [SLOTS_DEF];
    logic [COUNT_W-1:0]   refcnt_or_next [SLOTS_DEF];
    logic [SLOT_ID_W-1:0] free_slot_head;

    alloc_result_t expected_results[$];

    // Acquire: map the tile or count one more reference
    function automatic alloc_result_t predict_acquire(input logic [TILE_ID_W-1:0] tile);
        logic [SLOT_ID_W-1:0] s;
        if (tile == '0 || int'(tile) >= TILES_DEF)
            return '{slot: '0, status: ST_IGNORED};
        if (tile_mapped[tile])
        begin
            s = slot_of_tile[tile];
            if (refcnt_or_next[s] != COUNT_MAX)
                refcnt_or_next[s] = refcnt_or_next[s] + 1'b1;
            return '{slot: s, status: ST_HIT};
        end
        s = free_slot_head;
        if (s == '0)
            return '{slot: '0, status: ST_FULL};
        free_slot_head    = refcnt_or_next[s][SLOT_ID_W-1:0];
        slot_of_tile[tile] = s;
        tile_mapped[tile]  = 1'b1;
        tile_of_slot[s]    = tile;
        slot_mapped[s]     = 1'b1;
        refcnt_or_next[s]  = COUNT_W'(1);
        return '{slot: s, status: ST_NEW};
    endfunction

    // Release: drop one reference, free the slot on the last one
    function automatic alloc_result_t predict_release(input logic [SLOT_ID_W-1:0] s);
        if (s == '0 || !slot_mapped[s])
            return '{slot: '0, status: ST_IGNORED};
        if (refcnt_or_next[s] <= 1)
        begin
            tile_mapped[tile_of_slot[s]] = 1'b0;
            slot_mapped[s]    = 1'b0;
            tile_of_slot[s]   = '0;
            refcnt_or_next[s] = COUNT_W'(free_slot_head);
            free_slot_head    = s;
        end
        else
            refcnt_or_next[s] = refcnt_or_next[s] - 1'b1;
        return '{slot: s, status: ST_RELEASED};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        int            bad;
        bad = 0;
        if (!rst_n)
        begin
            for (int t = 0; t < TILES_DEF; t++)
            begin
                tile_mapped[t]  = 1'b0;
                slot_of_tile[t] = '0;
            end
            for (int s = 0; s < SLOTS_DEF; s++)
            begin
                slot_mapped[s]    = 1'b0;
                tile_of_slot[s]   = '0;
                refcnt_or_next[s] = (s == SLOTS_DEF - 1) ? '0 : COUNT_W'(s + 1);
            end
            free_slot_head = SLOT_ID_W'(1);
            expected_results.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // Results first: they belong to items taken at earlier edges
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: slot %0d, status %0d",
                           m_tdata[8:0], m_tdata[11:9]);
                    bad++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[8:0] !== want.slot)
                    begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want.slot, m_tdata[8:0]);
                        bad++;
                    end
                    if (m_tdata[11:9] !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tdata[11:9]);
                        bad++;
                    end
                end
            end
            // New request item
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_ACQUIRE)
                    expected_results.push_back(predict_acquire(s_tdata[9:0]));
                else
                    expected_results.push_back(predict_release(s_tdata[18:10]));
            end
            errors  <= errors + bad;
            pending <= expected_results.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and result traffic, verdict.
// Depends on rtsa_pkg, the allocator RTL and slot_map_checker.
module testbench;
    import rtsa_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // covers the clearing pass and the long hold
    localparam int HOLD_CYCLES = 300;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [9:0] tile_id, [18:10] slot_id, rest zero
    logic                 s_tuser;   // [0] action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [8:0] slot, [11:9] status, rest zero

    int   errors;
    int   pending;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;

    refcounted_tile_slot_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    slot_map_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offer one request item, with an occasional gap before it
    task automatic send_item(input logic act, input logic [TILE_ID_W-1:0] tile,
                             input logic [SLOT_ID_W-1:0] slot);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_TDATA_W - TILE_ID_W - SLOT_ID_W){1'b0}}, slot, tile};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Result side: random stalls, plus one long hold on request
    initial
    begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles where neither stream moves
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        logic                 draining;
        logic [TILE_ID_W-1:0] tile;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= ACT_ACQUIRE;
        s_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ignored requests, new, hit, decrement, free, reuse
        send_item(ACT_ACQUIRE, 10'd0,    9'h1FF);  // tile zero
        send_item(ACT_RELEASE, 10'h3FF,  9'd0);    // slot zero
        send_item(ACT_RELEASE, 10'd0,    9'h1FF);  // free slot
        send_item(ACT_ACQUIRE, 10'h3FF,  9'd0);    // new, slot 1
        send_item(ACT_ACQUIRE, 10'h3FF,  9'h1FF);  // hit
        send_item(ACT_ACQUIRE, 10'd1,    9'd0);
        send_item(ACT_ACQUIRE, 10'h200,  9'd0);
        send_item(ACT_RELEASE, 10'd0,    9'd1);    // decrement
        send_item(ACT_RELEASE, 10'h3FF,  9'd1);    // last reference, freed
        send_item(ACT_RELEASE, 10'd0,    9'd1);    // already free
        send_item(ACT_ACQUIRE, 10'h3FF,  9'd0);    // takes slot 1 back
        send_item(ACT_RELEASE, 10'd0,    9'd2);
        send_item(ACT_ACQUIRE, 10'h155,  9'h0AA);
        send_item(ACT_ACQUIRE, 10'h2AA,  9'h155);
        send_item(ACT_RELEASE, 10'h155,  9'h155);  // free slot
        send_item(ACT_RELEASE, 10'h2AA,  9'h0AA);  // free slot
        send_item(ACT_ACQUIRE, 10'h155,  9'h1FF);  // hit
        send_item(ACT_RELEASE, 10'h3FF,  9'd3);
        send_item(ACT_RELEASE, 10'd0,    9'd3);    // already free

        // Fill the table until the free list runs dry
        for (int n = 100; n < 660; n++)
            send_item(ACT_ACQUIRE, 10'(n), 9'($urandom));

        // Random mix, alternating drain and fill rounds; long result hold at start
        hold_req = 1'b1;
        for (int n = 0; n < 650; n++)
        begin
            draining = ((n / 100) % 2) == 0;
            if ($urandom_range(0, 99) < (draining ? 70 : 25))
                send_item(ACT_RELEASE, 10'($urandom), 9'($urandom_range(0, 511)));
            else
            begin
                tile = $urandom_range(0, 1) ? 10'($urandom_range(1, 63))
                                            : 10'($urandom_range(0, 1023));
                send_item(ACT_ACQUIRE, tile, 9'($urandom));
            end
        end

        // Closing stretch without idling
        idle_on = 1'b0;
        for (int n = 0; n < 100; n++)
            send_item($urandom_range(0, 1) ? ACT_RELEASE : ACT_ACQUIRE,
                      10'($urandom_range(0, 127)), 9'($urandom_range(0, 127)));
        s_tvalid <= 1'b0;

        // Drain outstanding results, then allow for stray ones
        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: refcounted_tile_slot_allocator.f
design/rtsa_pkg.sv
design/refcounted_tile_slot_allocator.sv
design/rtsa_checker.sv
tb/sv/slot_map_checker.sv
tb/sv/testbench.sv
